// ===== src/mlpq_pkg.sv =====
// ============================================================================
// mlpq_pkg: shared types and constants of the multi-level priority queue
// Holds the entry, prefix and control types of the cell chain, the status and
// command codes, and the default sizes of the queue.
// ============================================================================
`default_nettype none

package mlpq_pkg;

    localparam int VAL_W      = 32;
    localparam int LVL_W      = 3;
    // Prefix levels carry one more bit so that "no entry seen" ranks below
    // every real level.
    localparam int PREF_W     = LVL_W + 1;
    localparam logic [PREF_W-1:0] PREF_NONE = {1'b1, {LVL_W{1'b0}}};

    localparam int DEF_LEVELS = 5;
    localparam int DEF_DEPTH  = 16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_ENQ    = 3'd0,
        ST_DEQ    = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADPRI = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [LVL_W-1:0]        level;
    } t_entry;

    typedef struct packed {
        logic [PREF_W-1:0]       level;
        logic signed [VAL_W-1:0] value;
    } t_pref;

    typedef struct packed {
        logic             scan;
        logic             commit;
        logic [LVL_W-1:0] min_level;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== src/mlpq_cell.sv =====
// ============================================================================
// mlpq_cell: one slot of the priority queue chain
// Stores one entry, forwards the running most-urgent entry to its right
// neighbor during a scan, and takes its right neighbor's entry when closing up.
// ============================================================================
`default_nettype none

module mlpq_cell (
    input  wire                  i_clk,
    input  wire                  i_valid,
    input  wire                  i_load,
    input  mlpq_pkg::t_entry     i_load_entry,
    input  mlpq_pkg::t_cell_ctrl i_ctrl,
    input  mlpq_pkg::t_pref      i_left_pref,
    input  mlpq_pkg::t_entry     i_right_entry,
    output mlpq_pkg::t_entry     o_entry,
    output mlpq_pkg::t_pref      o_pref
);

    mlpq_pkg::t_entry r_entry;
    mlpq_pkg::t_pref  r_pref;
    logic [mlpq_pkg::PREF_W-1:0] w_own_level;

    assign w_own_level = {1'b0, r_entry.level};

    // Strictly lower wins, so the oldest entry of a level is kept.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan) begin
            if (i_valid && (w_own_level < i_left_pref.level)) begin
                r_pref.level <= w_own_level;
                r_pref.value <= r_entry.value;
            end else begin
                r_pref <= i_left_pref;
            end
        end
    end

    // A cell at or after the removed one takes its right neighbor's entry.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_entry;
        end else if (i_ctrl.commit && i_valid
                     && (r_pref.level == {1'b0, i_ctrl.min_level})) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_pref  = r_pref;

endmodule

`default_nettype wire

// ===== src/multi_level_priority_queue.sv =====
// ============================================================================
// multi_level_priority_queue: bounded queue ordered by priority, then age
// Holds up to DEPTH entries in arrival order in a chain of cells and dequeues
// the oldest entry of the most urgent level present.
// ============================================================================
`default_nettype none

// Each input item either enqueues a value at a priority from 1 (most urgent)
// to LEVELS, or dequeues, and every item gives exactly one result item with a
// status, the dequeued value and priority (zero unless the status is
// "dequeued"), and the occupancy after the step. An enqueue, a dequeue from an
// empty queue, a full queue and an invalid priority finish in the idle state, so
// such items can be taken back to back. A dequeue from a non-empty queue passes
// the idle, scan and done states: the item is taken, then a running minimum
// ripples through the chain of cells one cell per cycle, and in the done state,
// once the output register is free, the winner is reported while all later
// cells close up by one place at once. The chain length therefore sets the
// dequeue time. The result sits in an output register, and a new item is taken
// while it waits for the downstream side as long as that register can be freed
// in the same cycle. An invalid priority is checked before the full condition.

module multi_level_priority_queue #(
    parameter int LEVELS = mlpq_pkg::DEF_LEVELS,
    parameter int DEPTH  = mlpq_pkg::DEF_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int IN_W  = ((mlpq_pkg::VAL_W + mlpq_pkg::LVL_W + 7) / 8) * 8,
    localparam int OUT_W = ((mlpq_pkg::VAL_W + mlpq_pkg::LVL_W + CW + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: value (32, signed), priority_req (3), zero fill.
    input  wire  [IN_W-1:0]  s_axis_tdata,
    // Fields from bit 0: command (1).
    input  wire  [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    // Fields from bit 0: out_value (32, signed), out_priority (3),
    // occupancy (CW), zero fill.
    output logic [OUT_W-1:0] m_axis_tdata,
    // Fields from bit 0: status (3).
    output logic [2:0]       m_axis_tuser
);

    localparam int SW = $clog2(DEPTH);
    localparam int LW = mlpq_pkg::LVL_W;
    localparam int VW = mlpq_pkg::VAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_scan, n_scan;
    logic               r_ov, n_ov;
    mlpq_pkg::t_status  r_status, n_status;
    logic signed [VW-1:0] r_value, n_value;
    logic [LW-1:0]      r_pri, n_pri;

    logic               w_accept;
    logic               w_out_free;
    logic               w_cmd;
    logic signed [VW-1:0] w_in_value;
    logic [LW-1:0]      w_in_pri;
    logic               w_enq_ok;

    mlpq_pkg::t_cell_ctrl w_ctrl;
    mlpq_pkg::t_entry     w_load_entry;
    mlpq_pkg::t_entry     w_entry [DEPTH];
    mlpq_pkg::t_pref      w_pref  [DEPTH];
    mlpq_pkg::t_pref      w_best;

    assign w_cmd      = s_axis_tuser[0];
    assign w_in_value = s_axis_tdata[VW-1:0];
    assign w_in_pri   = s_axis_tdata[VW+LW-1:VW];

    assign w_out_free    = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // The winner of the scan leaves the last cell of the chain.
    assign w_best = w_pref[DEPTH-1];

    assign w_load_entry.value = w_in_value;
    assign w_load_entry.level = w_in_pri;

    assign w_enq_ok = w_accept && (w_cmd == mlpq_pkg::CMD_ENQ)
                      && (w_in_pri != '0) && (w_in_pri <= LW'(LEVELS))
                      && (r_count != CW'(DEPTH));

    assign w_ctrl.scan      = (r_state == S_SCAN);
    assign w_ctrl.commit    = (r_state == S_DONE) && w_out_free;
    assign w_ctrl.min_level = w_best.level[LW-1:0];

    // The chain: cell 0 is the head, the oldest entry.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mlpq_pkg::t_pref  w_left;
        mlpq_pkg::t_entry w_right;

        if (g == 0) begin : g_head
            assign w_left.level = mlpq_pkg::PREF_NONE;
            assign w_left.value = '0;
        end else begin : g_mid
            assign w_left = w_pref[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        mlpq_cell u_cell (
            .i_clk         (i_clk),
            .i_valid       (CW'(g) < r_count),
            .i_load        (w_enq_ok && (r_count == CW'(g))),
            .i_load_entry  (w_load_entry),
            .i_ctrl        (w_ctrl),
            .i_left_pref   (w_left),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_pref        (w_pref[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_scan   = r_scan;
        n_ov     = r_ov && !m_axis_tready;
        n_status = r_status;
        n_value  = r_value;
        n_pri    = r_pri;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value = '0;
                    n_pri   = '0;
                    if (w_cmd == mlpq_pkg::CMD_ENQ) begin
                        n_ov = 1'b1;
                        if ((w_in_pri == '0) || (w_in_pri > LW'(LEVELS))) begin
                            n_status = mlpq_pkg::ST_BADPRI;
                        end else if (r_count == CW'(DEPTH)) begin
                            n_status = mlpq_pkg::ST_FULL;
                        end else begin
                            n_status = mlpq_pkg::ST_ENQ;
                            n_count  = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_ov     = 1'b1;
                        n_status = mlpq_pkg::ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                        n_scan  = '0;
                    end
                end
            end
            S_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == SW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_status = mlpq_pkg::ST_DEQ;
                    n_value  = w_best.value;
                    n_pri    = w_best.level[LW-1:0];
                    n_count  = r_count - 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_scan  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_ov    <= n_ov;
        end
        r_status <= n_status;
        r_value  <= n_value;
        r_pri    <= n_pri;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_W'({r_count, r_pri, r_value});

endmodule

`default_nettype wire
